>>> hdl/pfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types, codes and constants of the page frame bitmap allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    // default geometry of the frame map
    localparam int NUM_FRAMES_DEF = 32768;
    localparam int WORD_BITS_DEF  = 64;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int FRAME_W    = 15;
    localparam int KIB_W      = 18;
    localparam int RESV_W     = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 1;

    // usable limit: (kib / 4) rounded down to a multiple of 8
    localparam int KIB_SHIFT   = 2;
    localparam int ALIGN_SHIFT = 3;

    // config reset values
    localparam logic [KIB_W-1:0]  MEMORY_KIB_RST      = 18'd131072;
    localparam logic [RESV_W-1:0] RESERVED_FRAMES_RST = 16'd2048;

    // result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_MARK    = 2'd2,
        MODE_INIT    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEMORY_KIB      = 1'd0,
        CFG_RESERVED_FRAMES = 1'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_INIT,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic div_step;
        logic rem_step;
        logic rmw_write;
        logic scan_start;
        logic scan_check;
        logic sweep_write;
        logic sweep_zero;
        logic res_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/page_frame_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// first-fit physical frame allocator over a one-bit-per-frame used map
// ----------------------------------------------------------------------------
// The map holds one bit per 4 KiB frame (1 = used) in a single-port-write,
// registered-read ram of NUM_FRAMES/WORD_BITS words; one item is in work at
// a time and its result waits in an output register. After reset a clearing
// pass writes one map word per cycle, all NUM_FRAMES/WORD_BITS words (512 at
// the defaults), before the first item is taken; config writes are taken at
// any time. An allocate reads map words from a low-water hint word onward
// (the hint tracks the lowest word that may hold a free frame) until it finds
// a free bit or reaches the last word; release and mark used run a reciprocal
// multiply that splits the frame into word and bit, then a read-modify-write
// of one word; initialize writes one word per cycle through the ram write
// port. A finished result waits in a staging register, and the block takes no
// new item, for as long as the sink holds the previous result in the output
// register.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // item transfer
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [FRAME_W-1:0]    frame,
    // result transfer
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FRAME_W-1:0]    frame_out,
    output logic                  status,
    // config writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: reset clear pass, mode dispatch, scan/sweep/rmw, result
    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item_mode (mode),
        .sts       (sts),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // map ram, word/bit split, scan encoder, init word, output register
    pfa_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .frame     (frame),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .frame_out (frame_out),
        .status    (status)
    );

`ifndef SYNTHESIS
    // one item in work: an accepted transfer leaves the input closed
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted transfer");

    // a failed allocate reports frame zero
    a_full_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FULL)) |-> (frame_out == '0))
        else $error("no-free-frame result with nonzero frame");

    // the map is never written while waiting for an item
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.sweep_write || cmd.rmw_write || cmd.scan_check))
        else $error("map write while idle");
`endif

endmodule
`default_nettype wire

>>> hdl/pfa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/pfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl
// sequencer of the frame allocator: clear pass, dispatch, scan, sweep, result
// ----------------------------------------------------------------------------
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] item_mode,
    input  sts_t              sts,
    output logic              in_ready,
    output cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode_t'(item_mode))
                        MODE_ALLOC:   state_next = ST_SCAN_RD;
                        MODE_RELEASE: state_next = ST_DIV;
                        MODE_MARK:    state_next = ST_DIV;
                        MODE_INIT:    state_next = ST_INIT;
                    endcase
                end
            end
            ST_DIV:      state_next = ST_REM;
            ST_REM:      state_next = ST_RMW_RD;
            ST_RMW_RD:   state_next = ST_RMW_WR;
            ST_RMW_WR:   state_next = ST_RESULT;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_INIT:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_write = 1'b1;
                cmd.sweep_zero  = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_DIV:      cmd.div_step    = 1'b1;
            ST_REM:      cmd.rem_step    = 1'b1;
            ST_RMW_RD:   cmd             = '0;
            ST_RMW_WR:   cmd.rmw_write   = 1'b1;
            ST_SCAN_RD:  cmd.scan_start  = 1'b1;
            ST_SCAN_CHK: cmd.scan_check  = 1'b1;
            ST_INIT:     cmd.sweep_write = 1'b1;
            ST_RESULT:   cmd.res_load    = sts.out_free;
            default:     cmd             = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/pfa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_dp
// datapath: frame map ram, word/bit split, scan, init sweep, output register
// ----------------------------------------------------------------------------
module pfa_dp
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MODE_W-1:0]     mode,
    input  logic [FRAME_W-1:0]    frame,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FRAME_W-1:0]    frame_out,
    output logic                  status
);

    localparam int DEPTH     = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SPAN      = DEPTH * WORD_BITS;
    localparam int CMP_W     = ($clog2(SPAN + 1) > 17) ? $clog2(SPAN + 1) : 17;
    // frame / WORD_BITS as a multiply by a rounded-up reciprocal, exact for
    // every FRAME_W-bit frame
    localparam int DIV_SHIFT = FRAME_W + BIT_W;
    localparam int RECIP     = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W    = FRAME_W + DIV_SHIFT + 1;
    localparam int LAST_BITS = NUM_FRAMES - (DEPTH - 1) * WORD_BITS;

    // item and config
    mode_t              mode_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               in_range_reg;
    logic [KIB_W-1:0]   kib_reg;
    logic [RESV_W-1:0]  resv_reg;

    // word/bit split
    logic [FRAME_W-1:0] q_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [PROD_W-1:0]  div_prod;
    logic [FRAME_W-1:0] q_scaled;
    logic [IDX_W-1:0]   q_idx;

    // scan and sweep
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     hint_reg;
    logic [CMP_W-1:0]     base_reg;
    logic                 ptr_last;
    logic [WORD_BITS-1:0] last_pad;
    logic [WORD_BITS-1:0] word_pad;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_free;
    logic [BIT_W-1:0]     low_bit;
    logic                 scan_found;
    logic [CMP_W-1:0]     alloc_frame;
    logic [CMP_W-1:0]     limit_ext;
    logic [CMP_W-1:0]     resv_ext;
    logic [WORD_BITS-1:0] init_word;
    logic [WORD_BITS-1:0] bit_onehot;

    // result staging and output register
    logic [FRAME_W-1:0] res_frame_reg;
    logic               res_status_reg;
    logic               out_valid_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_status_reg;
    logic               out_free;

    // ram ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    pfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_prod   = PROD_W'(frame_reg) * PROD_W'(RECIP);
    assign q_scaled   = FRAME_W'(q_reg * FRAME_W'(WORD_BITS));
    assign q_idx      = IDX_W'(q_reg);
    assign bit_onehot = WORD_BITS'(1) << bit_reg;
    assign ptr_last   = (ptr_reg == IDX_W'(DEPTH - 1));

    // bits past the last frame read as used
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            last_pad[b] = (b >= LAST_BITS);
        end
    end

    assign word_pad   = ptr_last ? last_pad : '0;
    assign free_bits  = ~(ram_rdata | word_pad);
    assign scan_found = |free_bits;
    // isolate lowest free bit, then encode it
    assign low_free   = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb
    begin
        low_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_free[b])
            begin
                low_bit = low_bit | BIT_W'(b);
            end
        end
    end

    assign alloc_frame = CMP_W'(CMP_W'(ptr_reg) * CMP_W'(WORD_BITS)) + CMP_W'(low_bit);

    // init word: used below the reserved count or at/above the usable limit
    assign limit_ext = CMP_W'((kib_reg >> (KIB_SHIFT + ALIGN_SHIFT)) << ALIGN_SHIFT);
    assign resv_ext  = CMP_W'(resv_reg);

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            init_word[b] = ((base_reg + CMP_W'(b)) < resv_ext) ||
                           ((base_reg + CMP_W'(b)) >= limit_ext);
        end
    end

    // ram read address
    always_comb
    begin
        priority if (cmd.scan_start)
        begin
            ram_raddr = hint_reg;
        end
        else if (cmd.scan_check)
        begin
            ram_raddr = ptr_reg + IDX_W'(1);
        end
        else
        begin
            ram_raddr = q_idx;
        end
    end

    // ram write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = ram_rdata | low_free;
        priority if (cmd.sweep_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = cmd.sweep_zero ? '0 : init_word;
        end
        else if (cmd.rmw_write)
        begin
            ram_we    = in_range_reg;
            ram_waddr = q_idx;
            ram_wdata = (mode_reg == MODE_MARK) ? (ram_rdata | bit_onehot)
                                                : (ram_rdata & ~bit_onehot);
        end
        else if (cmd.scan_check)
        begin
            ram_we = scan_found;
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            hint_reg <= '0;
            base_reg <= '0;
            kib_reg  <= MEMORY_KIB_RST;
            resv_reg <= RESERVED_FRAMES_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MEMORY_KIB:      kib_reg  <= cfg_data[KIB_W-1:0];
                    CFG_RESERVED_FRAMES: resv_reg <= cfg_data[RESV_W-1:0];
                endcase
            end

            if (cmd.load_item)
            begin
                ptr_reg  <= '0;
                base_reg <= '0;
            end
            else if (cmd.scan_start)
            begin
                ptr_reg <= hint_reg;
            end
            else if (cmd.sweep_write || (cmd.scan_check && !scan_found))
            begin
                ptr_reg  <= ptr_reg + IDX_W'(1);
                base_reg <= base_reg + CMP_W'(WORD_BITS);
            end

            // every word below the hint is full
            if (cmd.sweep_write)
            begin
                hint_reg <= '0;
            end
            else if (cmd.scan_check && scan_found)
            begin
                hint_reg <= ptr_reg;
            end
            else if (cmd.rmw_write && in_range_reg && (mode_reg == MODE_RELEASE) &&
                     (q_idx < hint_reg))
            begin
                hint_reg <= q_idx;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg       <= mode_t'(mode);
            frame_reg      <= frame;
            in_range_reg   <= (CMP_W'(frame) < CMP_W'(NUM_FRAMES));
            res_frame_reg  <= frame;
            res_status_reg <= STATUS_DONE;
        end
        else if (cmd.scan_check)
        begin
            if (scan_found)
            begin
                res_frame_reg  <= FRAME_W'(alloc_frame);
                res_status_reg <= STATUS_DONE;
            end
            else if (ptr_last)
            begin
                res_frame_reg  <= '0;
                res_status_reg <= STATUS_FULL;
            end
        end

        if (cmd.div_step)
        begin
            q_reg <= FRAME_W'(div_prod >> DIV_SHIFT);
        end
        if (cmd.rem_step)
        begin
            bit_reg <= BIT_W'(frame_reg - q_scaled);
        end

        if (cmd.res_load)
        begin
            out_frame_reg  <= res_frame_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.scan_done  = scan_found || ptr_last;
    assign sts.sweep_last = ptr_last;
    assign sts.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign frame_out = out_frame_reg;
    assign status    = out_status_reg;

endmodule
`default_nettype wire
